### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on every clock edge out of reset
`define ISS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// same-cycle implication
`define ISS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ISS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### design/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// operation codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package iss_pkg;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_CONTAINS = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_DUMP     = 3'd4
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // latch the accepted item
      logic scan_start;   // restart the store scan
      logic scan_run;     // issue the next scan read
      logic fetch_last;   // read the last occupied entry
      logic write_add;    // append the item value
      logic write_move;   // move the last entry into the hit slot
      logic mark_drop;    // remember that the add was refused
      logic clear_count;  // empty the set
      logic dump_next;    // advance the dump to the next member
      logic rsp_single;   // load a single result
      logic rsp_member;   // load a dump member result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       scan_done;
      logic       found;
      logic       full;
      logic       empty;
      logic       out_free;
      logic       dump_last;
   } status_type;

endpackage

### design/iss_dpath.sv
// ----------------------------------------------------------------------------
// iss_dpath
// entry memory, member count, scan compare and result register
// ----------------------------------------------------------------------------
module iss_dpath #(
   parameter int CAPACITY = 16,
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_op,
   input  logic signed [31:0]  req_value,
   input  iss_pkg::cmd_type    cmd,
   output iss_pkg::status_type status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_found,
   output logic                rsp_dropped,
   output logic [CW-1:0]       rsp_count,
   output logic signed [31:0]  rsp_member,
   output logic                rsp_member_valid,
   output logic                rsp_last
);
   import iss_pkg::*;

   logic signed [31:0] mem [CAPACITY];

   logic [2:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      scan_cnt_ff;
   logic [CW-1:0]      emit_cnt_ff;
   logic signed [31:0] rd_data_ff;
   logic               cmp_vld_ff;
   logic [IW-1:0]      cmp_idx_ff;
   logic [IW-1:0]      hit_idx_ff;
   logic               found_ff;
   logic               drop_ff;
   logic signed [31:0] prev_ff;
   logic               have_prev_ff;
   logic signed [31:0] best_ff;
   logic               best_vld_ff;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic               rsp_dropped_ff;
   logic [CW-1:0]      rsp_count_ff;
   logic signed [31:0] rsp_member_ff;
   logic               rsp_member_valid_ff;
   logic               rsp_last_ff;

   logic               scan_issue;
   logic [CW-1:0]      count_dec;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               cmp_hit;
   logic               take_best;
   logic [CW:0]        emit_next;
   logic               dump_last;
   logic               out_free;

   assign scan_issue = cmd.scan_run && (scan_cnt_ff < count_ff);
   assign count_dec  = count_ff - 1'b1;
   assign rd_addr    = cmd.fetch_last ? count_dec[IW-1:0] : scan_cnt_ff[IW-1:0];

   assign wr_en   = cmd.write_add || cmd.write_move;
   assign wr_addr = cmd.write_add ? count_ff[IW-1:0] : hit_idx_ff;
   assign wr_data = cmd.write_add ? value_ff : rd_data_ff;

   assign cmp_hit   = cmp_vld_ff && (rd_data_ff == value_ff);
   // next dump member: smallest entry above the one sent last
   assign take_best = cmp_vld_ff
                      && (!have_prev_ff || (rd_data_ff > prev_ff))
                      && (!best_vld_ff || (rd_data_ff < best_ff));

   assign emit_next = {1'b0, emit_cnt_ff} + 1'b1;
   assign dump_last = (emit_next == {1'b0, count_ff});
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status           = '0;
      status.op        = op_ff;
      status.scan_done = (scan_cnt_ff == count_ff) && !cmp_vld_ff;
      status.found     = found_ff;
      status.full      = (count_ff == CW'(CAPACITY));
      status.empty     = (count_ff == '0);
      status.out_free  = out_free;
      status.dump_last = dump_last;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         scan_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         cmp_vld_ff <= scan_issue;
         if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (cmp_hit) begin
            found_ff <= 1'b1;
         end
         if (take_best) begin
            best_vld_ff <= 1'b1;
         end
         if (cmd.scan_start) begin
            scan_cnt_ff <= '0;
            found_ff    <= 1'b0;
            best_vld_ff <= 1'b0;
         end
         if (cmd.load) begin
            drop_ff      <= 1'b0;
            have_prev_ff <= 1'b0;
            emit_cnt_ff  <= '0;
         end
         if (cmd.mark_drop) begin
            drop_ff <= 1'b1;
         end
         if (cmd.dump_next) begin
            have_prev_ff <= 1'b1;
            emit_cnt_ff  <= emit_cnt_ff + 1'b1;
         end
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.write_add) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.write_move) begin
            count_ff <= count_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_cnt_ff[IW-1:0];
      if (cmp_hit) begin
         hit_idx_ff <= cmp_idx_ff;
      end
      if (take_best) begin
         best_ff <= rd_data_ff;
      end
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      if (cmd.dump_next) begin
         prev_ff <= best_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_single || cmd.rsp_member) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_single) begin
         rsp_found_ff        <= found_ff;
         rsp_dropped_ff      <= drop_ff;
         rsp_count_ff        <= count_ff;
         rsp_member_ff       <= '0;
         rsp_member_valid_ff <= 1'b0;
         rsp_last_ff         <= 1'b1;
      end else if (cmd.rsp_member) begin
         rsp_found_ff        <= 1'b0;
         rsp_dropped_ff      <= 1'b0;
         rsp_count_ff        <= count_ff;
         rsp_member_ff       <= best_ff;
         rsp_member_valid_ff <= 1'b1;
         rsp_last_ff         <= dump_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_dropped      = rsp_dropped_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_member       = rsp_member_ff;
   assign rsp_member_valid = rsp_member_valid_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### design/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// operation sequencer: scan, update, dump passes and result hand-off
// ----------------------------------------------------------------------------
module iss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  iss_pkg::status_type status,
   output iss_pkg::cmd_type    cmd
);
   import iss_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISPATCH = 8'b0000_0010,
      ST_SCAN     = 8'b0000_0100,
      ST_FETCH    = 8'b0000_1000,
      ST_MOVE     = 8'b0001_0000,
      ST_RESP     = 8'b0010_0000,
      ST_DSCAN    = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_ADD, OP_REMOVE, OP_CONTAINS: begin
                  state_in = ST_SCAN;
               end
               OP_CLEAR: begin
                  cmd.clear_count = 1'b1;
                  state_in        = ST_RESP;
               end
               OP_DUMP: begin
                  state_in = status.empty ? ST_RESP : ST_DSCAN;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_RESP;
               if (status.op == OP_ADD) begin
                  if (!status.found) begin
                     if (status.full) begin
                        cmd.mark_drop = 1'b1;
                     end else begin
                        cmd.write_add = 1'b1;
                     end
                  end
               end else if (status.op == OP_REMOVE && status.found) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch_last = 1'b1;
            state_in       = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.write_move = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.rsp_single = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DSCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.rsp_member = 1'b1;
               cmd.dump_next  = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_DSCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/integer_set_store_core.sv
// ----------------------------------------------------------------------------
// integer_set_store_core
// set of distinct signed 32-bit integers with add, remove, contains, clear
// and sorted dump
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_op, req_value
//  rsp      out  rsp_valid/rsp_stall   rsp_found, rsp_dropped, rsp_count,
//                                      rsp_member, rsp_member_valid, rsp_last
//
//  one entry scanned a cycle; add, contains and remove scan the set, a remove
//  hit then fetches the last entry and moves it into the hit slot; clear, empty
//  dump and other codes skip the scan; a dump rescans the set for each member
//  the next transfer in is taken the cycle after the last result loads
//  reset empties the set at once; no clearing pass
//  a stalled result holds the controller in its hand-off state
// ----------------------------------------------------------------------------
module integer_set_store_core #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_op,
   input  logic signed [31:0]                 req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic                               rsp_dropped,
   output logic [$clog2(CAPACITY + 1)-1:0]    rsp_count,
   output logic signed [31:0]                 rsp_member,
   output logic                               rsp_member_valid,
   output logic                               rsp_last
);
   import iss_pkg::*;

   cmd_type    cmd;
   status_type status;

   iss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iss_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_dropped      (rsp_dropped),
      .rsp_count        (rsp_count),
      .rsp_member       (rsp_member),
      .rsp_member_valid (rsp_member_valid),
      .rsp_last         (rsp_last)
   );

endmodule

### design/iss_checker.sv
// ----------------------------------------------------------------------------
// iss_checker
// port-level checks on the set store core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iss_checker #(
   parameter int CAPACITY = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [2:0]                      req_op,
   input logic signed [31:0]              req_value,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_found,
   input logic                            rsp_dropped,
   input logic [$clog2(CAPACITY + 1)-1:0] rsp_count,
   input logic signed [31:0]              rsp_member,
   input logic                            rsp_member_valid,
   input logic                            rsp_last
);

   // a refused add only happens on a full set, which it leaves full
   `ISS_ASSERT_IMP(a_drop_full, clock, reset, rsp_valid && rsp_dropped, rsp_count == CAPACITY && !rsp_found, "dropped add without a full set")

   // no new item is taken while a dump is still sending members
   `ISS_ASSERT_IMP(a_dump_busy, clock, reset, rsp_valid && !rsp_last, rsp_member_valid && req_stall, "item accepted in the middle of a dump")

   // member results carry no lookup flags and come from a non-empty set
   `ISS_ASSERT_IMP(a_member_flags, clock, reset, rsp_valid && rsp_member_valid, !rsp_found && !rsp_dropped && rsp_count != 0, "bad flags on a member result")

   // every transfer in starts a busy period
   `ISS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input not stalled after a transfer")

   `ISS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_member) && $stable(rsp_last), "stalled result changed")

endmodule

bind integer_set_store_core iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for integer_set_store_core: a behavioral set model
// predicts the results of every accepted request; a monitor compares each
// result transfer field by field, while the request side idles in bursts and
// the result side stalls randomly, on a pattern and in one long hold-off
// ----------------------------------------------------------------------------
module testbench;
   import iss_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int POOL_SIZE     = 20;
   localparam int WATCHDOG_MAX  = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;

   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_type;

   typedef struct {
      logic                found;
      logic                dropped;
      logic [COUNT_W-1:0]  count;
      logic signed [31:0]  member;
      logic                member_valid;
      logic                last;
   } set_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [2:0]                req_op;
   logic signed [31:0]        req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_found;
   logic                      rsp_dropped;
   logic [COUNT_W-1:0]        rsp_count;
   logic signed [31:0]        rsp_member;
   logic                      rsp_member_valid;
   logic                      rsp_last;

   // set model
   logic signed [31:0]        model_entries [CAPACITY];
   int                        model_count;
   set_result_type            expected_results [$];

   int                        mismatches;
   int                        idle_cycles;
   int                        burst_left;
   bit                        sender_idles;
   rx_mode_type               rx_mode;
   logic [15:0]               stall_pattern;
   int                        pattern_pos;
   int                        hold_request;
   int                        hold_left;
   logic signed [31:0]        value_pool [POOL_SIZE];

   integer_set_store_core #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_dropped      (rsp_dropped),
      .rsp_count        (rsp_count),
      .rsp_member       (rsp_member),
      .rsp_member_valid (rsp_member_valid),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic int find_member(input logic signed [31:0] value);
      for (int i = 0; i < model_count; i++)
         if (model_entries[i] == value)
            return i;
      return -1;
   endfunction

   function automatic void sort_members();
      int                 m;
      logic signed [31:0] t;
      for (int i = 0; i + 1 < model_count; i++) begin
         m = i;
         for (int j = i + 1; j < model_count; j++)
            if (model_entries[j] < model_entries[m])
               m = j;
         t = model_entries[i];
         model_entries[i] = model_entries[m];
         model_entries[m] = t;
      end
   endfunction

   function automatic void push_result(input logic found, input logic dropped,
                                       input logic signed [31:0] member,
                                       input logic member_valid, input logic last);
      set_result_type r;
      r.found        = found;
      r.dropped      = dropped;
      r.count        = model_count[COUNT_W-1:0];
      r.member       = member;
      r.member_valid = member_valid;
      r.last         = last;
      expected_results.push_back(r);
   endfunction

   function automatic void apply_set_op(input logic [2:0] op,
                                        input logic signed [31:0] value);
      int hit;
      hit = find_member(value);
      case (op)
         OP_ADD: begin
            if (hit >= 0) begin
               push_result(1'b1, 1'b0, '0, 1'b0, 1'b1);
            end else if (model_count >= CAPACITY) begin
               push_result(1'b0, 1'b1, '0, 1'b0, 1'b1);
            end else begin
               model_entries[model_count] = value;
               model_count++;
               push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               // last entry fills the hole
               model_count--;
               model_entries[hit] = model_entries[model_count];
            end
            push_result(hit >= 0, 1'b0, '0, 1'b0, 1'b1);
         end
         OP_CONTAINS: push_result(hit >= 0, 1'b0, '0, 1'b0, 1'b1);
         OP_CLEAR: begin
            model_count = 0;
            push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
         end
         OP_DUMP: begin
            if (model_count == 0) begin
               push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
            end else begin
               sort_members();
               for (int i = 0; i < model_count; i++)
                  push_result(1'b0, 1'b0, model_entries[i], 1'b1, i + 1 == model_count);
            end
         end
         default: push_result(1'b0, 1'b0, '0, 1'b0, 1'b1);
      endcase
   endfunction

   // ---------------------------------------------------------------- request side

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [2:0] op, input logic signed [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = sender_idles ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      apply_set_op(op, value);
      @(negedge clock);
   endtask

   function automatic logic [2:0] pick_op(input int add_pct);
      int r;
      if ($urandom_range(0, 99) < add_pct)
         return OP_ADD;
      r = $urandom_range(0, 19);
      if (r < 8)  return OP_REMOVE;
      if (r < 14) return OP_CONTAINS;
      if (r < 15) return OP_CLEAR;
      if (r < 18) return OP_DUMP;
      return 3'($urandom_range(OP_DUMP + 1, 7));
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      endcase
   endfunction

   function automatic void refresh_pool();
      for (int i = 0; i < POOL_SIZE; i++)
         if (i % 3 == 0)
            value_pool[i] = $signed($urandom_range(0, 30)) - 15;
         else
            value_pool[i] = $urandom();
   endfunction

   // ---------------------------------------------------------------- result side

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_FREE:  rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 20);
            RX_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 65);
            default: begin
               rsp_stall <= stall_pattern[pattern_pos];
               pattern_pos = (pattern_pos + 1) % 16;
            end
         endcase
      end
   end

   task automatic check_field(input string field, input logic signed [31:0] expected,
                              input logic signed [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", field, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      set_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("rsp_found", want.found, rsp_found);
            check_field("rsp_dropped", want.dropped, rsp_dropped);
            check_field("rsp_count", want.count, rsp_count);
            check_field("rsp_member", want.member, rsp_member);
            check_field("rsp_member_valid", want.member_valid, rsp_member_valid);
            check_field("rsp_last", want.last, rsp_last);
         end
      end
   end

   // no transfer on either channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      rx_mode = RX_LIGHT;
      sender_idles = 1'b1;
      send_item(OP_DUMP, 32'sd0);              // empty set
      send_item(OP_REMOVE, 32'sd5);            // absent, empty set
      send_item(OP_ADD, 32'sh7FFF_FFFF);
      send_item(OP_ADD, 32'sh8000_0000);
      send_item(OP_ADD, 32'sd0);
      send_item(OP_ADD, -32'sd1);
      send_item(OP_ADD, 32'sd1);
      send_item(OP_ADD, -32'sd1);              // already present
      send_item(OP_CONTAINS, 32'sh8000_0000);
      send_item(OP_CONTAINS, 32'sd2);
      send_item(OP_DUMP, 32'sd0);              // signed order across the sign bit
      send_item(OP_REMOVE, 32'sd0);
      send_item(OP_REMOVE, 32'sd0);
      send_item(3'd5, 32'shFFFF_FFFF);         // unused codes
      send_item(3'd6, 32'sd0);
      send_item(3'd7, 32'sh5555_AAAA);
      send_item(OP_DUMP, 32'sd0);
      send_item(OP_CLEAR, 32'sd9);
      send_item(OP_CONTAINS, 32'sh7FFF_FFFF);
      send_item(OP_DUMP, 32'sd0);
   endtask

   task automatic test_full_store();
      logic signed [31:0] base;
      base = $urandom();
      rx_mode = RX_HEAVY;
      send_item(OP_CLEAR, 32'sd0);
      for (int i = 0; i < CAPACITY; i++)
         send_item(OP_ADD, base + i * 7919);
      send_item(OP_ADD, base + CAPACITY * 7919);    // refused, store full
      send_item(OP_ADD, base);                      // present while full
      send_item(OP_CONTAINS, base + 5 * 7919);
      send_item(OP_DUMP, 32'sd0);
      send_item(OP_REMOVE, base + 3 * 7919);
      send_item(OP_ADD, base + CAPACITY * 7919);
      send_item(OP_DUMP, 32'sd0);
   endtask

   task automatic test_random_traffic(input int items, input rx_mode_type mode,
                                      input bit idles, input int add_pct);
      rx_mode = mode;
      stall_pattern = $urandom();
      sender_idles = idles;
      refresh_pool();
      for (int i = 0; i < items; i++)
         send_item(pick_op(add_pct), pick_value());
   endtask

   // long receiver hold-off: the block fills and must stall the request side
   task automatic test_backpressure();
      rx_mode = RX_FREE;
      sender_idles = 1'b0;
      hold_request = HOLD_CYCLES;
      send_item(OP_ADD, pick_value());
      send_item(OP_ADD, pick_value());
      send_item(OP_DUMP, 32'sd0);
      for (int i = 0; i < 10; i++)
         send_item(pick_op(50), pick_value());
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_ADD;
      req_value    = '0;
      rsp_stall    = 1'b0;
      mismatches   = 0;
      idle_cycles  = 0;
      burst_left   = 0;
      sender_idles = 1'b1;
      rx_mode      = RX_FREE;
      stall_pattern = 16'h0F35;
      pattern_pos  = 0;
      hold_request = 0;
      hold_left    = 0;
      model_count  = 0;
      refresh_pool();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_store();
      test_random_traffic(80, RX_FREE, 1'b0, 45);
      test_random_traffic(100, RX_LIGHT, 1'b1, 45);
      test_random_traffic(60, RX_PATTERN, 1'b1, 75);
      test_backpressure();
      test_random_traffic(80, RX_HEAVY, 1'b1, 40);
      test_random_traffic(60, RX_PATTERN, 1'b0, 60);

      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results still outstanding", expected_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
